@@ rtl/dpw_pkg.sv @@
// shared types, widths and constants for the depth pixel to world point block
`default_nettype none

package dpw_pkg;

  localparam int PIXEL_INDEX_BITS = 10;

  localparam int DEPTH_W = 16;
  localparam int INV_W = 20;
  localparam int CTR_W = 14;
  localparam int ROW_W = 64;
  localparam int COEF_W = 16;
  localparam int OUT_W = 19;
  localparam int CFG_IDX_W = 3;

  localparam int CAM_FRAC = 24;
  localparam int ROT_FRAC = 18;

  localparam int PIX_SCALED_W = PIXEL_INDEX_BITS + 4;
  localparam int OFF_W = ((PIX_SCALED_W > CTR_W) ? PIX_SCALED_W : CTR_W) + 1;
  localparam int PX_W = OFF_W + DEPTH_W + 1;
  localparam int MX_W = PX_W + INV_W + 1;
  localparam int CAM_W = OFF_W + DEPTH_W + INV_W - CAM_FRAC + 1;
  localparam int PROD_W = COEF_W + CAM_W;
  localparam int ACC_W = PROD_W + 2;
  localparam int RES_W = ACC_W - ROT_FRAC;

  localparam int IQ_DEPTH = 4;
  localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int STAGES = 5;

  localparam logic [INV_W-1:0] RST_INV_FOCAL_X = 20'd45962;
  localparam logic [INV_W-1:0] RST_INV_FOCAL_Y = 20'd45962;
  localparam logic [CTR_W-1:0] RST_CENTER_X = 14'd4096;
  localparam logic [CTR_W-1:0] RST_CENTER_Y = 14'd3392;
  localparam logic [ROW_W-1:0] RST_ROT_ROW_X = 64'h4000_0000_0000_0000;
  localparam logic [ROW_W-1:0] RST_ROT_ROW_Y = 64'h0000_4000_0000_0000;
  localparam logic [ROW_W-1:0] RST_ROT_ROW_Z = 64'h0000_0000_4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_FOCAL_X = 3'd0,
    REG_INV_FOCAL_Y = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_ROT_ROW_X   = 3'd4,
    REG_ROT_ROW_Y   = 3'd5,
    REG_ROT_ROW_Z   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [INV_W-1:0] inv_focal_x;
    logic [INV_W-1:0] inv_focal_y;
    logic [CTR_W-1:0] center_x;
    logic [CTR_W-1:0] center_y;
    logic [ROW_W-1:0] rot_row_x;
    logic [ROW_W-1:0] rot_row_y;
    logic [ROW_W-1:0] rot_row_z;
  } cfg_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic ok;
    logic [OFF_W-1:0] off_x;
    logic [OFF_W-1:0] off_y;
    logic [DEPTH_W-1:0] depth;
  } work_t;

  typedef struct packed {
    logic empty;
    work_t head;
  } work_q_t;

endpackage

`default_nettype wire

@@ rtl/depth_pixel_to_world_point.sv @@
// top level: depth pixel to world point back-projection with rigid transform
`default_nettype none

// Takes one depth pixel per clock while full is low (push/full) and returns one world point
// per pixel, in order (empty/pop). The back end is fully pipelined, so it sustains one pixel
// per cycle while the result queue has room; its steps are offset times depth, times inverse
// focal, rounding, the nine transform products, then sum with the translation, round and
// saturate. An intake queue of four beats and a result queue of eight beats separate the two
// sides; the back end only issues a beat when the result queue has room for it. A depth of
// zero yields point_valid low with zero coordinates. Write configuration only while the block
// is idle.
module depth_pixel_to_world_point (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [dpw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [dpw_pkg::ROW_W-1:0]            cfg_data,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic [dpw_pkg::PIXEL_INDEX_BITS-1:0] column,
  input  wire logic [dpw_pkg::PIXEL_INDEX_BITS-1:0] row,
  input  wire logic [dpw_pkg::DEPTH_W-1:0]          depth_mm,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic                                      point_valid,
  output logic signed [dpw_pkg::OUT_W-1:0]          world_x,
  output logic signed [dpw_pkg::OUT_W-1:0]          world_y,
  output logic signed [dpw_pkg::OUT_W-1:0]          world_z
);

  dpw_pkg::cfg_t cfg;
  dpw_pkg::work_q_t work_q;
  logic take;

  dpw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .column   (column),
    .row      (row),
    .depth_mm (depth_mm),
    .take     (take),
    .work_q   (work_q)
  );

  dpw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .work_q      (work_q),
    .take        (take),
    .empty       (empty),
    .pop         (pop),
    .point_valid (point_valid),
    .world_x     (world_x),
    .world_y     (world_y),
    .world_z     (world_z)
  );

endmodule

`default_nettype wire

@@ rtl/dpw_cfg.sv @@
// configuration register file with write port
`default_nettype none

module dpw_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [dpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dpw_pkg::ROW_W-1:0]      cfg_data,
  output dpw_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_focal_x <= dpw_pkg::RST_INV_FOCAL_X;
      cfg.inv_focal_y <= dpw_pkg::RST_INV_FOCAL_Y;
      cfg.center_x <= dpw_pkg::RST_CENTER_X;
      cfg.center_y <= dpw_pkg::RST_CENTER_Y;
      cfg.rot_row_x <= dpw_pkg::RST_ROT_ROW_X;
      cfg.rot_row_y <= dpw_pkg::RST_ROT_ROW_Y;
      cfg.rot_row_z <= dpw_pkg::RST_ROT_ROW_Z;
    end else if (cfg_we) begin
      unique case (dpw_pkg::cfg_reg_t'(cfg_index))
        dpw_pkg::REG_INV_FOCAL_X: cfg.inv_focal_x <= cfg_data[dpw_pkg::INV_W-1:0];
        dpw_pkg::REG_INV_FOCAL_Y: cfg.inv_focal_y <= cfg_data[dpw_pkg::INV_W-1:0];
        dpw_pkg::REG_CENTER_X:    cfg.center_x <= cfg_data[dpw_pkg::CTR_W-1:0];
        dpw_pkg::REG_CENTER_Y:    cfg.center_y <= cfg_data[dpw_pkg::CTR_W-1:0];
        dpw_pkg::REG_ROT_ROW_X:   cfg.rot_row_x <= cfg_data;
        dpw_pkg::REG_ROT_ROW_Y:   cfg.rot_row_y <= cfg_data;
        dpw_pkg::REG_ROT_ROW_Z:   cfg.rot_row_z <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/dpw_front.sv @@
// intake: classifies pixels, forms centered offsets and queues them for the back end
`default_nettype none

module dpw_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire dpw_pkg::cfg_t                        cfg,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic [dpw_pkg::PIXEL_INDEX_BITS-1:0] column,
  input  wire logic [dpw_pkg::PIXEL_INDEX_BITS-1:0] row,
  input  wire logic [dpw_pkg::DEPTH_W-1:0]          depth_mm,
  input  wire logic                                 take,
  output dpw_pkg::work_q_t                          work_q
);

  dpw_pkg::work_t mem [dpw_pkg::IQ_DEPTH];
  logic [dpw_pkg::IQ_PTR_W-1:0] wr_ptr;
  logic [dpw_pkg::IQ_PTR_W-1:0] rd_ptr;
  logic [dpw_pkg::IQ_PTR_W:0] count;
  logic wr_en;
  logic rd_en;
  dpw_pkg::work_t item;

  always_comb begin
    item.ok = (depth_mm != '0);
    item.off_x = dpw_pkg::OFF_W'({column, 4'b0000}) - dpw_pkg::OFF_W'(cfg.center_x);
    item.off_y = dpw_pkg::OFF_W'({row, 4'b0000}) - dpw_pkg::OFF_W'(cfg.center_y);
    item.depth = depth_mm;
  end

  assign full = (count == (dpw_pkg::IQ_PTR_W + 1)'(dpw_pkg::IQ_DEPTH));
  assign wr_en = push && !full;
  assign rd_en = take && (count != '0);
  assign work_q.empty = (count == '0);
  assign work_q.head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/dpw_back.sv @@
// arithmetic pipeline: back-projection, rigid transform, saturation and result queue
`default_nettype none

module dpw_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire dpw_pkg::cfg_t                cfg,
  input  wire dpw_pkg::work_q_t             work_q,
  output logic                              take,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              point_valid,
  output logic signed [dpw_pkg::OUT_W-1:0]  world_x,
  output logic signed [dpw_pkg::OUT_W-1:0]  world_y,
  output logic signed [dpw_pkg::OUT_W-1:0]  world_z
);

  localparam int OUT_W = dpw_pkg::OUT_W;
  localparam int CAM_W = dpw_pkg::CAM_W;
  localparam int PX_W = dpw_pkg::PX_W;
  localparam int MX_W = dpw_pkg::MX_W;
  localparam int PROD_W = dpw_pkg::PROD_W;
  localparam int ACC_W = dpw_pkg::ACC_W;
  localparam int RES_W = dpw_pkg::RES_W;
  localparam int CNT_W = dpw_pkg::OQ_PTR_W + 2;

  localparam logic signed [MX_W-1:0] CAM_HALF = MX_W'(1) << (dpw_pkg::CAM_FRAC - 1);
  localparam logic signed [ACC_W-1:0] ROT_HALF = ACC_W'(1) << (dpw_pkg::ROT_FRAC - 1);
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

  typedef struct packed {
    logic point_valid;
    logic [OUT_W-1:0] world_x;
    logic [OUT_W-1:0] world_y;
    logic [OUT_W-1:0] world_z;
  } res_t;

  function automatic logic [OUT_W-1:0] saturate(input logic [RES_W-1:0] r);
    logic [RES_W-OUT_W:0] hi;
    hi = r[RES_W-1:OUT_W-1];
    if (hi == '0 || hi == '1) begin
      return r[OUT_W-1:0];
    end
    return r[RES_W-1] ? OUT_MIN : OUT_MAX;
  endfunction

  // stage valids
  logic [dpw_pkg::STAGES-1:0] v;

  // stage 0
  dpw_pkg::work_t w0;
  // stage 1
  logic ok1;
  logic signed [PX_W-1:0] px1;
  logic signed [PX_W-1:0] py1;
  logic signed [CAM_W-1:0] cz1;
  // stage 2
  logic ok2;
  logic signed [MX_W-1:0] mx2;
  logic signed [MX_W-1:0] my2;
  logic signed [CAM_W-1:0] cz2;
  // stage 3
  logic ok3;
  logic signed [CAM_W-1:0] cam3 [3];
  // stage 4
  logic ok4;
  logic signed [PROD_W-1:0] prod4 [3][3];

  logic signed [MX_W-1:0] rx;
  logic signed [MX_W-1:0] ry;
  logic [dpw_pkg::ROW_W-1:0] rows [3];
  logic signed [ACC_W-1:0] acc [3];
  logic [OUT_W-1:0] coord [3];
  res_t res;

  res_t oq [dpw_pkg::OQ_DEPTH];
  logic [dpw_pkg::OQ_PTR_W-1:0] oq_wr;
  logic [dpw_pkg::OQ_PTR_W-1:0] oq_rd;
  logic [dpw_pkg::OQ_PTR_W:0] oq_count;
  logic [CNT_W-1:0] committed;
  logic oq_push;
  logic oq_pop;

  assign committed = CNT_W'(oq_count) + CNT_W'($countones(v));
  assign take = !work_q.empty && (committed < CNT_W'(dpw_pkg::OQ_DEPTH));

  assign rows[0] = cfg.rot_row_x;
  assign rows[1] = cfg.rot_row_y;
  assign rows[2] = cfg.rot_row_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[dpw_pkg::STAGES-2:0], take};
    end
  end

  always_comb begin
    rx = mx2 + CAM_HALF;
    ry = my2 + CAM_HALF;
  end

  always_ff @(posedge clk) begin
    w0 <= work_q.head;

    ok1 <= w0.ok;
    px1 <= PX_W'($signed(w0.off_x) * $signed({1'b0, w0.depth}));
    py1 <= PX_W'($signed(w0.off_y) * $signed({1'b0, w0.depth}));
    cz1 <= CAM_W'({w0.depth, 4'b0000});

    ok2 <= ok1;
    mx2 <= MX_W'(px1 * $signed({1'b0, cfg.inv_focal_x}));
    my2 <= MX_W'(py1 * $signed({1'b0, cfg.inv_focal_y}));
    cz2 <= cz1;

    ok3 <= ok2;
    cam3[0] <= rx[dpw_pkg::CAM_FRAC +: CAM_W];
    cam3[1] <= ry[dpw_pkg::CAM_FRAC +: CAM_W];
    cam3[2] <= cz2;

    ok4 <= ok3;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod4[r][c] <= PROD_W'($signed(rows[r][dpw_pkg::ROW_W-1-16*c -: dpw_pkg::COEF_W])
                       * cam3[c]);
      end
    end
  end

  // sum with translation, round to mm, saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = ACC_W'(prod4[r][0]) + ACC_W'(prod4[r][1]) + ACC_W'(prod4[r][2])
             + (ACC_W'($signed(rows[r][dpw_pkg::COEF_W-1:0])) <<< dpw_pkg::ROT_FRAC)
             + ROT_HALF;
      coord[r] = saturate(acc[r][dpw_pkg::ROT_FRAC +: RES_W]);
    end
    res.point_valid = ok4;
    res.world_x = ok4 ? coord[0] : '0;
    res.world_y = ok4 ? coord[1] : '0;
    res.world_z = ok4 ? coord[2] : '0;
  end

  assign oq_push = v[dpw_pkg::STAGES-1];
  assign empty = (oq_count == '0);
  assign oq_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr <= '0;
      oq_rd <= '0;
      oq_count <= '0;
    end else begin
      if (oq_push) begin
        oq_wr <= oq_wr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + 1'b1;
      end
      if (oq_push && !oq_pop) begin
        oq_count <= oq_count + 1'b1;
      end else if (oq_pop && !oq_push) begin
        oq_count <= oq_count - 1'b1;
      end
    end
  end

  assign point_valid = oq[oq_rd].point_valid;
  assign world_x = oq[oq_rd].world_x;
  assign world_y = oq[oq_rd].world_y;
  assign world_z = oq[oq_rd].world_z;

  // result queue never overrun
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    oq_push |-> (oq_count != (dpw_pkg::OQ_PTR_W + 1)'(dpw_pkg::OQ_DEPTH)) || oq_pop)
    else $error("result queue written while full");

  // beats in flight plus queued results stay within the result queue
  a_credit: assert property (@(posedge clk) disable iff (rst)
    committed <= CNT_W'(dpw_pkg::OQ_DEPTH))
    else $error("pipeline holds more beats than the result queue can take");

  // an issued beat reaches the result queue after passing every pipeline stage
  a_latency: assert property (@(posedge clk) disable iff (rst)
    take |-> ##(dpw_pkg::STAGES) oq_push)
    else $error("issued beat lost in pipeline");

  // a dropped pixel carries zero coordinates
  a_zero_invalid: assert property (@(posedge clk) disable iff (rst)
    (oq_push && !ok4) |-> (res.world_x == '0 && res.world_y == '0 && res.world_z == '0))
    else $error("invalid pixel with nonzero coordinates");

endmodule

`default_nettype wire
